>>> hw/rtl/dmoc_pkg.sv
// Shared types, codes and helpers for the door and motion occupancy classifier.
`timescale 1ns / 1ps

package dmoc_pkg;

  // Operation carried in the input tuser bit
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam logic [15:0] SLEEP_WAIT_RESET = 16'd300;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MOTION = 2'd1,
    MODE_DOOR   = 2'd2
  } mode_t;

  // Control for one tick/seconds counter
  typedef struct packed {
    logic en;   // state advances this cycle
    logic clr;  // zero the counter
    logic inc;  // count one tick
  } ctr_ctl_t;

  // Round-to-nearest seconds from whole seconds plus a round-up flag,
  // saturated to eight bits.
  function automatic logic [7:0] sec_round(input logic [15:0] sec, input logic up);
    logic [7:0] res;
    if (sec >= 16'd255) begin
      res = 8'd255;
    end else begin
      res = sec[7:0] + {7'd0, up};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/dmoc_dwell_ctr.sv
// Saturating tick counter kept as whole seconds plus ticks within the second.
`timescale 1ns / 1ps

module dmoc_dwell_ctr #(
  parameter int TICKS_PER_SECOND = 8,
  parameter int CNT_W            = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dmoc_pkg::ctr_ctl_t   ctl,
  output logic [CNT_W-1:0]     sec_nxt,  // whole seconds after this update
  output logic                 up_nxt    // remainder is at least half a second
);

  localparam int RW        = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int MAX_TICKS = (1 << CNT_W) - 1;
  localparam int Q_MAX     = MAX_TICKS / TICKS_PER_SECOND;
  localparam int R_MAX     = MAX_TICKS % TICKS_PER_SECOND;
  localparam logic [RW-1:0] R_LAST = RW'(TICKS_PER_SECOND - 1);
  localparam logic [RW:0]   T_CMP  = (RW + 1)'(TICKS_PER_SECOND);

  logic [CNT_W-1:0] sec_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    rem_nxt;
  logic             at_max;

  assign at_max = (sec_r == CNT_W'(Q_MAX)) && (rem_r == RW'(R_MAX));

  always_comb begin
    sec_nxt = sec_r;
    rem_nxt = rem_r;
    if (ctl.clr) begin
      sec_nxt = '0;
      rem_nxt = '0;
    end else if (ctl.inc && !at_max) begin
      if (rem_r == R_LAST) begin
        sec_nxt = sec_r + CNT_W'(1);
        rem_nxt = '0;
      end else begin
        rem_nxt = rem_r + RW'(1);
      end
    end
  end

  assign up_nxt = ({rem_nxt, 1'b0} >= T_CMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0;
      rem_r <= '0;
    end else if (ctl.en) begin
      sec_r <= sec_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> hw/rtl/door_motion_occupancy_classifier_core.sv
// Top level of the door and motion occupancy classifier.
`timescale 1ns / 1ps

// Door and motion occupancy classifier. Each input transfer is either a sensor
// tick (tuser = 0: five motion reads and the door level) or a clear of the five
// dwell counters (tuser = 1). Every input transfer yields exactly one output
// transfer carrying the mode, the five dwell times in rounded seconds
// (saturated at 255), the sleep request and the latch setting, all taken after
// the update. The block takes one transfer per clock while the result side is
// not held off: an input register feeds combinational classification and
// counter update into the result register, so an input transfer passes the
// input register and then the result register before out_tvalid offers it.
// The state update loop closes through that logic. Counters keep whole
// seconds and the tick remainder side by side, so no divider is needed. Write
// cfg_wr_data (quiet seconds before sleep, reset 300) only while idle.
module door_motion_occupancy_classifier_core #(
  parameter int TICKS_PER_SECOND = 8,
  parameter int DEBOUNCE_READS   = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // sleep_wait_seconds
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [dmoc_pkg::IN_TDATA_W-1:0]  in_tdata,  // [4:0] motion_samples,
                                                     // [5] door_level, [7:6] zero
  input  logic        in_tuser,       // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [dmoc_pkg::OUT_TDATA_W-1:0] out_tdata // [1:0] mode, [9:2] exiting_seconds,
                                      // [17:10] entering_seconds,
                                      // [25:18] motion_only_seconds,
                                      // [33:26] door_only_seconds,
                                      // [41:34] quiet_seconds, [42] sleep_request,
                                      // [43] latch_hold, [47:44] zero
);

  localparam logic [4:0] READ_MASK =
    (DEBOUNCE_READS >= 5) ? 5'h1f : 5'((1 << DEBOUNCE_READS) - 1);

  localparam int NUM_DWELL = 5;
  localparam int D_EXIT    = 0;
  localparam int D_ENTER   = 1;
  localparam int D_MOTION  = 2;
  localparam int D_DOOR    = 3;
  localparam int D_QUIET   = 4;

  // Input register
  logic        in_valid_r;
  logic        op_r;
  logic [4:0]  motion_r;
  logic        door_r;

  // Result register
  logic        out_valid_r;
  logic [dmoc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [dmoc_pkg::OUT_TDATA_W-1:0] out_data_nxt;

  // Classifier state
  dmoc_pkg::mode_t mode_r, mode_nxt;
  logic        sleep_r, sleep_nxt;
  logic        latch_r, latch_nxt;
  logic [15:0] wait_r;

  logic        advance;
  logic        fire;
  logic        tick;
  logic        clr_all;
  logic        m;
  logic        d;
  logic        go_active;
  logic        go_quiet;
  logic [NUM_DWELL-1:0] dwell_inc;

  dmoc_pkg::ctr_ctl_t dwell_ctl [NUM_DWELL];
  dmoc_pkg::ctr_ctl_t run_ctl;
  logic [15:0] dwell_sec [NUM_DWELL];
  logic [NUM_DWELL-1:0] dwell_up;
  logic [7:0]  dwell_rnd [NUM_DWELL];
  logic [23:0] run_sec;
  logic        run_up;

  // Handshake: advance whenever the result slot is free or being drained
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign fire       = in_valid_r && advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign tick    = fire && (op_r == dmoc_pkg::OP_TICK);
  assign clr_all = fire && (op_r == dmoc_pkg::OP_CLEAR);
  assign m       = |(motion_r & READ_MASK);
  assign d       = door_r;

  // Hold the input transfer until it moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= in_tuser;
      motion_r <= in_tdata[4:0];
      door_r   <= in_tdata[5];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= dmoc_pkg::SLEEP_WAIT_RESET;
    end else if (cfg_wr_en) begin
      wait_r <= cfg_wr_data;
    end
  end

  // Classify the tick: mode, which dwell counter moves, active vs quiet
  always_comb begin
    mode_nxt  = mode_r;
    dwell_inc = '0;
    go_active = 1'b0;
    go_quiet  = 1'b0;
    if (tick) begin
      if (m && d && (mode_r == dmoc_pkg::MODE_MOTION)) begin
        dwell_inc[D_EXIT] = 1'b1;
        go_active         = 1'b1;
      end else if (m && d && (mode_r == dmoc_pkg::MODE_DOOR)) begin
        dwell_inc[D_ENTER] = 1'b1;
        go_active          = 1'b1;
      end else if (!m && !d) begin
        dwell_inc[D_QUIET] = 1'b1;
        go_quiet           = 1'b1;
        mode_nxt           = dmoc_pkg::MODE_IDLE;
      end else if (m && !d) begin
        dwell_inc[D_MOTION] = 1'b1;
        go_active           = 1'b1;
        mode_nxt            = dmoc_pkg::MODE_MOTION;
      end else if (!m && d) begin
        dwell_inc[D_DOOR] = 1'b1;
        go_active         = 1'b1;
        mode_nxt          = dmoc_pkg::MODE_DOOR;
      end else begin
        // both sensors, no prior mode: no counter moves, still active, back to idle
        go_active = 1'b1;
        mode_nxt  = dmoc_pkg::MODE_IDLE;
      end
    end

    latch_nxt = latch_r;
    if (go_active) begin
      latch_nxt = 1'b0;
    end else if (go_quiet) begin
      latch_nxt = 1'b1;
    end

    // Sleep check runs after every tick on the updated quiet run
    sleep_nxt = sleep_r;
    if (tick) begin
      sleep_nxt = (sleep_r && !go_active) || (run_sec >= {8'd0, wait_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= dmoc_pkg::MODE_IDLE;
      sleep_r <= 1'b0;
      latch_r <= 1'b1;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      sleep_r <= sleep_nxt;
      latch_r <= latch_nxt;
    end
  end

  // Dwell counters
  for (genvar i = 0; i < NUM_DWELL; i++) begin : g_dwell
    assign dwell_ctl[i] = '{en: fire, clr: clr_all, inc: dwell_inc[i]};

    dmoc_dwell_ctr #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND),
      .CNT_W(16)
    ) u_dwell (
      .clk(clk),
      .rst_n(rst_n),
      .ctl(dwell_ctl[i]),
      .sec_nxt(dwell_sec[i]),
      .up_nxt(dwell_up[i])
    );

    assign dwell_rnd[i] = dmoc_pkg::sec_round(dwell_sec[i], dwell_up[i]);
  end

  // Quiet run: cleared by any activity, never by the clear operation
  assign run_ctl = '{en: fire, clr: go_active, inc: go_quiet};

  dmoc_dwell_ctr #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .CNT_W(24)
  ) u_run (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(run_ctl),
    .sec_nxt(run_sec),
    .up_nxt(run_up)
  );

  // Pack the result; the run remainder flag is masked off and bit 44 stays zero
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[1:0]   = mode_nxt;
    out_data_nxt[9:2]   = dwell_rnd[D_EXIT];
    out_data_nxt[17:10] = dwell_rnd[D_ENTER];
    out_data_nxt[25:18] = dwell_rnd[D_MOTION];
    out_data_nxt[33:26] = dwell_rnd[D_DOOR];
    out_data_nxt[41:34] = dwell_rnd[D_QUIET];
    out_data_nxt[42]    = sleep_nxt;
    out_data_nxt[43]    = latch_nxt;
    out_data_nxt[44]    = run_up & 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Input side stalls only when both stages are full and the sink holds off
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  // A quiet tick puts the latch back into hold
  a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && !m && !d) |=> latch_r)
    else $error("latch not held after quiet tick");

  // Any active tick opens the latch
  a_active_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && (m || d)) |=> !latch_r)
    else $error("latch not in pass-through after activity");

  // The clear operation leaves mode alone and reports zeroed dwell times
  a_clear_keeps_mode: assert property (@(posedge clk) disable iff (!rst_n)
    clr_all |=> (mode_r == $past(mode_r)) && out_valid_r && (out_data_r[41:2] == '0))
    else $error("clear operation disturbed mode or counters");

  // The sleep request only rises on a processed transfer
  a_sleep_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sleep_r) |-> $past(tick))
    else $error("sleep request rose without a tick");

endmodule

>>> bench/tb.sv
// Self-checking stream testbench for the door and motion occupancy classifier core.
`timescale 1ns / 1ps

// Drive sensor ticks and clears into the core, predict every report in lockstep
// and compare each result transfer field by field against the oldest
// prediction. Named tests run in turn from one initial block. They share one
// sender task and one checking process. A receiver process stalls the result
// channel at random and, when the pressure test asks, holds off long enough
// for the core to back up.
module tb;

  localparam int TICKS_PER_SECOND = 8;
  localparam int DEBOUNCE_READS   = 5;
  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int SETTLE_CYCLES    = 4;    // keep margin after the last checked report
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int STALL_LIMIT      = 1000; // cycles without any transfer
  localparam int PHASE_ITEMS      = 140;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [23:0] RUN_MAX = 24'hFFFFFF;
  // Only the first DEBOUNCE_READS reads count, and never more than the five carried.
  localparam logic [4:0] READ_MASK =
      (DEBOUNCE_READS >= 5) ? 5'h1F : 5'((1 << DEBOUNCE_READS) - 1);

  // One report as the core presents it after an update
  typedef struct {
    logic [1:0] mode;
    logic [7:0] exiting;
    logic [7:0] entering;
    logic [7:0] motion_only;
    logic [7:0] door_only;
    logic [7:0] quiet;
    logic       sleep_req;
    logic       latch_hold;
  } occ_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [4:0] motion_samples, [5] door_level, [7:6] zero
  logic        in_tuser = dmoc_pkg::OP_TICK; // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [1:0] mode, [9:2] exiting, [17:10] entering,
                                // [25:18] motion_only, [33:26] door_only,
                                // [41:34] quiet, [42] sleep_request,
                                // [43] latch_hold, [47:44] zero

  // Predicted occupancy state, advanced once per accepted input transfer
  dmoc_pkg::mode_t occ_mode = dmoc_pkg::MODE_IDLE;
  logic [15:0] exit_ticks = '0;
  logic [15:0] enter_ticks = '0;
  logic [15:0] motion_ticks = '0;
  logic [15:0] door_ticks = '0;
  logic [15:0] quiet_ticks = '0;
  logic [23:0] quiet_run = '0;
  logic        sleep_pending = 1'b0;
  logic        latch_held = 1'b1;
  logic [15:0] sleep_wait = dmoc_pkg::SLEEP_WAIT_RESET;

  occ_report_t pending_reports[$];
  int          mismatches = 0;
  int          sent_items = 0;
  int          quiet_cycles = 0;
  bit          burst_mode = 1'b0;    // both sides run without idling
  bit          long_hold_req = 1'b0; // receiver holds off once for a long stretch

  door_motion_occupancy_classifier_core #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .DEBOUNCE_READS  (DEBOUNCE_READS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] bump_dwell(input logic [15:0] c);
    return (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

  // Round ticks to the nearest second, ties up, and clip to eight bits.
  function automatic logic [7:0] dwell_seconds(input logic [15:0] c);
    int s;
    s = (2 * int'(c) + TICKS_PER_SECOND) / (2 * TICKS_PER_SECOND);
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  // Advance the predicted state by one input item and return the report it yields.
  function automatic occ_report_t classify_tick(input logic op, input logic [4:0] motion,
                                                input logic door);
    occ_report_t r;
    logic        m;
    logic        active;
    m = |(motion & READ_MASK);
    if (op == dmoc_pkg::OP_CLEAR) begin
      // Clear only the dwell counters; mode, quiet run, sleep and latch persist.
      exit_ticks   = '0;
      enter_ticks  = '0;
      motion_ticks = '0;
      door_ticks   = '0;
      quiet_ticks  = '0;
    end else begin
      active = 1'b1;
      if (occ_mode == dmoc_pkg::MODE_MOTION && m && door) begin
        exit_ticks = bump_dwell(exit_ticks);
      end else if (occ_mode == dmoc_pkg::MODE_DOOR && m && door) begin
        enter_ticks = bump_dwell(enter_ticks);
      end else if (!m && !door) begin
        quiet_ticks = bump_dwell(quiet_ticks);
        quiet_run   = (quiet_run == RUN_MAX) ? quiet_run : quiet_run + 24'd1;
        occ_mode    = dmoc_pkg::MODE_IDLE;
        latch_held  = 1'b1;
        active      = 1'b0;
      end else if (m && !door) begin
        motion_ticks = bump_dwell(motion_ticks);
        occ_mode     = dmoc_pkg::MODE_MOTION;
      end else if (!m && door) begin
        door_ticks = bump_dwell(door_ticks);
        occ_mode   = dmoc_pkg::MODE_DOOR;
      end else begin
        // Both sensors at once with no prior mode: count nothing, fall back to idle.
        occ_mode = dmoc_pkg::MODE_IDLE;
      end
      if (active) begin
        quiet_run     = '0;
        sleep_pending = 1'b0;
        latch_held    = 1'b0;
      end
      if (int'(quiet_run) / TICKS_PER_SECOND >= int'(sleep_wait)) begin
        sleep_pending = 1'b1;
      end
    end
    r.mode        = occ_mode;
    r.exiting     = dwell_seconds(exit_ticks);
    r.entering    = dwell_seconds(enter_ticks);
    r.motion_only = dwell_seconds(motion_ticks);
    r.door_only   = dwell_seconds(door_ticks);
    r.quiet       = dwell_seconds(quiet_ticks);
    r.sleep_req   = sleep_pending;
    r.latch_hold  = latch_held;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // Match every result transfer against the oldest pending prediction.
  always @(posedge clk) begin
    occ_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $error("result transfer with no prediction pending");
      end else begin
        want = pending_reports.pop_front();
        compare_field("mode", want.mode, out_tdata[1:0]);
        compare_field("exiting_seconds", want.exiting, out_tdata[9:2]);
        compare_field("entering_seconds", want.entering, out_tdata[17:10]);
        compare_field("motion_only_seconds", want.motion_only, out_tdata[25:18]);
        compare_field("door_only_seconds", want.door_only, out_tdata[33:26]);
        compare_field("quiet_seconds", want.quiet, out_tdata[41:34]);
        compare_field("sleep_request", want.sleep_req, out_tdata[42]);
        compare_field("latch_hold", want.latch_hold, out_tdata[43]);
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls per transfer, one long hold on request
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        // Hold off while the sender keeps offering, so the core backs up.
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 7);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap and record its prediction once accepted.
  // Leave tvalid high on return so a back-to-back item needs no second drive.
  task automatic send_sample(input logic op, input logic [4:0] motion, input logic door);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, door, motion};
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(classify_tick(op, motion, door));
    sent_items++;
  endtask

  // Drop valid and wait until every predicted report has been checked.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the quiet wait only once the core has drained.
  task automatic write_sleep_wait(input logic [15:0] secs);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= secs;
    @(posedge clk);
    sleep_wait = secs;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [4:0] any_motion();
    return 5'($urandom_range(1, 31));
  endfunction

  // One short stretch of plausible traffic with random sensor content.
  task automatic run_scenario();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        // Someone walks out: motion first, then door with motion.
        n = $urandom_range(1, 4);
        repeat (n) send_sample(dmoc_pkg::OP_TICK, any_motion(), 1'b0);
        n = $urandom_range(1, 6);
        repeat (n) send_sample(dmoc_pkg::OP_TICK, any_motion(), 1'b1);
      end
      2, 3: begin
        // Someone walks in: door first, then door with motion.
        n = $urandom_range(1, 4);
        repeat (n) send_sample(dmoc_pkg::OP_TICK, 5'd0, 1'b1);
        n = $urandom_range(1, 6);
        repeat (n) send_sample(dmoc_pkg::OP_TICK, any_motion(), 1'b1);
      end
      4, 5: begin
        n = $urandom_range(1, 60);
        repeat (n) send_sample(dmoc_pkg::OP_TICK, 5'd0, 1'b0);
      end
      6: begin
        send_sample(dmoc_pkg::OP_CLEAR, 5'($urandom), 1'($urandom));
      end
      7: begin
        // Both sensors from idle, which the classifier ignores.
        send_sample(dmoc_pkg::OP_TICK, 5'd0, 1'b0);
        send_sample(dmoc_pkg::OP_TICK, any_motion(), 1'b1);
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          send_sample(($urandom_range(0, 15) == 0) ? dmoc_pkg::OP_CLEAR : dmoc_pkg::OP_TICK,
                      5'($urandom), 1'($urandom));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk every class of tick, each motion read alone, rounding and the clear.
  task automatic test_directed();
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b0);  // quiet from reset
    send_sample(dmoc_pkg::OP_TICK, 5'b00001, 1'b0);  // motion only
    send_sample(dmoc_pkg::OP_TICK, 5'b00010, 1'b1);  // exiting
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b1);  // door only
    send_sample(dmoc_pkg::OP_TICK, 5'b00100, 1'b1);  // entering
    send_sample(dmoc_pkg::OP_TICK, 5'b01000, 1'b1);  // entering again
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b0);  // back to idle
    send_sample(dmoc_pkg::OP_TICK, 5'b10000, 1'b1);  // both from idle: ignored
    send_sample(dmoc_pkg::OP_TICK, 5'b11111, 1'b0);
    send_sample(dmoc_pkg::OP_TICK, 5'b11111, 1'b1);
    send_sample(dmoc_pkg::OP_CLEAR, 5'b11111, 1'b1);
    // Three quiet ticks still round down; the fourth rounds up to one second.
    repeat (4) send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b0);
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b1);
    send_sample(dmoc_pkg::OP_CLEAR, 5'b00000, 1'b0);
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b0);
  endtask

  // Zero wait sets the request on every tick; a short wait needs whole seconds.
  task automatic test_sleep_wait();
    write_sleep_wait(16'd0);
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b0);
    send_sample(dmoc_pkg::OP_TICK, 5'b00110, 1'b0);  // clears the request, then sets it again
    send_sample(dmoc_pkg::OP_CLEAR, 5'b00000, 1'b0); // keeps request and latch
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b1);
    write_sleep_wait(16'd1);
    repeat (9) send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b0);
    send_sample(dmoc_pkg::OP_CLEAR, 5'b00000, 1'b1);
    send_sample(dmoc_pkg::OP_TICK, 5'b00000, 1'b1);
  endtask

  // Keep offering at full rate while the receiver holds off.
  task automatic test_pressure();
    settle_block();
    burst_mode    = 1'b1;
    long_hold_req = 1'b1;
    repeat (40) send_sample(dmoc_pkg::OP_TICK, 5'($urandom), 1'($urandom));
    burst_mode = 1'b0;
    settle_block();
  endtask

  // Random traffic over several quiet-wait settings.
  task automatic test_random_traffic();
    logic [15:0] waits[4];
    int          stop_at;
    waits[0] = 16'd0;
    waits[1] = 16'($urandom_range(1, 3));
    waits[2] = 16'($urandom_range(2, 7));
    waits[3] = dmoc_pkg::SLEEP_WAIT_RESET;
    foreach (waits[i]) begin
      write_sleep_wait(waits[i]);
      stop_at = sent_items + PHASE_ITEMS;
      while (sent_items < stop_at) run_scenario();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sleep_wait();
    test_pressure();
    test_random_traffic();
    settle_block();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dmoc_pkg.sv
hw/rtl/dmoc_dwell_ctr.sv
hw/rtl/door_motion_occupancy_classifier_core.sv
bench/tb.sv
